/* rtl/twr_pkg.sv */
// Shared types, constants and a helper function of the transaction rewriter.
package twr_pkg;

  localparam logic OP_TX   = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic CFG_TARGET_OUTPUT = 1'b0;
  localparam logic CFG_REPL_LENGTH   = 1'b1;

  localparam logic [31:0] OUTPOINT_BYTES = 32'd36;
  localparam logic [31:0] SEQ_BYTES      = 32'd4;
  localparam logic [31:0] VALUE_BYTES    = 32'd8;

  localparam logic [7:0] VI_16 = 8'hfd;
  localparam logic [7:0] VI_32 = 8'hfe;
  localparam logic [7:0] SEGWIT_FLAG = 8'h01;

  typedef enum logic [13:0] {
    PH_VERSION   = 14'h0001,
    PH_MARKER    = 14'h0002,
    PH_MARKER2   = 14'h0004,
    PH_NIN       = 14'h0008,
    PH_IN_PREFIX = 14'h0010,
    PH_IN_SLEN   = 14'h0020,
    PH_IN_SCRIPT = 14'h0040,
    PH_IN_SEQ    = 14'h0080,
    PH_NOUT      = 14'h0100,
    PH_OUT_VALUE = 14'h0200,
    PH_OUT_SLEN  = 14'h0400,
    PH_OUT_COPY  = 14'h0800,
    PH_OUT_SKIP  = 14'h1000,
    PH_TAIL      = 14'h2000
  } phase_e;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_BYTES = 4'b0010,
    BK_RPREP = 4'b0100,
    BK_REPL  = 4'b1000
  } back_state_e;

  typedef enum logic {
    CMD_BYTES = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [2:0]      nbytes;
    logic [5:0][7:0] data;
    logic            repl;
    logic [5:0]      rlen;
    logic            end_tx;
    logic            status;
  } cmd_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [4:0][7:0] b;
  } count_enc_t;

  function automatic count_enc_t put_count(input logic [31:0] v);
    count_enc_t r;
    r.b = '0;
    if (v < 32'(VI_16)) begin
      r.n    = 3'd1;
      r.b[0] = v[7:0];
    end else if (v <= 32'h0000ffff) begin
      r.n    = 3'd3;
      r.b[0] = VI_16;
      r.b[1] = v[7:0];
      r.b[2] = v[15:8];
    end else begin
      r.n    = 3'd5;
      r.b[0] = VI_32;
      r.b[1] = v[7:0];
      r.b[2] = v[15:8];
      r.b[3] = v[23:16];
      r.b[4] = v[31:24];
    end
    return r;
  endfunction

endpackage

/* rtl/twr_front.sv */
// Front parser: accepts bytes, tracks the transaction layout and issues emit commands.
module twr_front #(
  parameter int REPL_MAX = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  repl_index_i,
  input  logic        last_byte_i,
  input  logic [15:0] target_output_i,
  input  logic [5:0]  repl_length_i,
  output logic        cmd_push_o,
  output twr_pkg::cmd_t cmd_o
);
  import twr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  ver_q, ver_d;
  logic [31:0] items_q, items_d;
  logic [31:0] vacc_q, vacc_d;
  logic [3:0]  vleft_q, vleft_d;
  logic [3:0]  vwidth_q, vwidth_d;
  logic [31:0] sl_q, sl_d;
  logic [15:0] oc_q, oc_d;
  logic [31:0] tw_q, tw_d;
  logic [2:0]  tc_q, tc_d;
  logic        err_q, err_d;

  always_comb begin
    logic            do_count;
    logic            held;
    logic            end_out;
    logic            proc_err;
    logic            vdone;
    logic [31:0]     v;
    logic [3:0]      pos;
    logic [31:0]     acc;
    logic [2:0]      en;
    logic [5:0][7:0] ed;
    logic            repl;
    logic [5:0]      rn;
    count_enc_t      ce;

    phase_d  = phase_q;
    ver_d    = ver_q;
    items_d  = items_q;
    vacc_d   = vacc_q;
    vleft_d  = vleft_q;
    vwidth_d = vwidth_q;
    sl_d     = sl_q;
    oc_d     = oc_q;
    tw_d     = tw_q;
    tc_d     = tc_q;
    do_count = 1'b0;
    held     = 1'b0;
    end_out  = 1'b0;
    proc_err = 1'b0;
    vdone    = 1'b0;
    v        = '0;
    pos      = vwidth_q - vleft_q;
    acc      = '0;
    en       = '0;
    ed       = '0;
    repl     = 1'b0;
    rn       = (repl_length_i > 6'(REPL_MAX)) ? 6'(REPL_MAX) : repl_length_i;
    ce       = '0;

    if (!err_q) begin
      unique case (phase_q)
        PH_VERSION: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          ver_d = ver_q + 2'd1;
          if (ver_q == 2'd3) begin
            phase_d = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (data_byte_i == 8'h00) begin
            phase_d = PH_MARKER2;
          end else begin
            phase_d  = PH_NIN;
            do_count = 1'b1;
          end
        end
        PH_MARKER2: begin
          if (data_byte_i == SEGWIT_FLAG) begin
            phase_d = PH_NIN;
          end else begin
            held     = 1'b1;
            items_d  = '0;
            phase_d  = PH_NOUT;
            do_count = 1'b1;
          end
        end
        PH_NIN, PH_IN_SLEN, PH_NOUT, PH_OUT_SLEN: begin
          do_count = 1'b1;
        end
        PH_IN_PREFIX: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          sl_d  = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            phase_d = PH_IN_SLEN;
          end
        end
        PH_IN_SCRIPT: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          sl_d  = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            sl_d    = SEQ_BYTES;
            phase_d = PH_IN_SEQ;
          end
        end
        PH_IN_SEQ: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          sl_d  = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            items_d = items_q - 32'd1;
            if (items_q == 32'd1) begin
              phase_d = PH_NOUT;
            end else begin
              sl_d    = OUTPOINT_BYTES;
              phase_d = PH_IN_PREFIX;
            end
          end
        end
        PH_OUT_VALUE: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          sl_d  = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            phase_d = PH_OUT_SLEN;
          end
        end
        PH_OUT_COPY: begin
          en    = 3'd1;
          ed[0] = data_byte_i;
          sl_d  = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            end_out = 1'b1;
          end
        end
        PH_OUT_SKIP: begin
          sl_d = sl_q - 32'd1;
          if (sl_q == 32'd1) begin
            end_out = 1'b1;
          end
        end
        PH_TAIL: begin
          tw_d = {tw_q[23:0], data_byte_i};
          if (tc_q < 3'd4) begin
            tc_d = tc_q + 3'd1;
          end
        end
        default: begin
          proc_err = 1'b1;
        end
      endcase
    end

    if (do_count) begin
      if (vleft_q == 4'd0) begin
        if (data_byte_i < VI_16) begin
          vdone = 1'b1;
          v     = {24'd0, data_byte_i};
        end else begin
          vwidth_d = (data_byte_i == VI_16) ? 4'd2 : ((data_byte_i == VI_32) ? 4'd4 : 4'd8);
          vleft_d  = vwidth_d;
          vacc_d   = '0;
        end
      end else begin
        acc = vacc_q;
        if (pos[3:2] == 2'b00) begin
          acc = vacc_q | ({24'd0, data_byte_i} << {pos[1:0], 3'b000});
        end
        vacc_d  = acc;
        vleft_d = vleft_q - 4'd1;
        if (vleft_q == 4'd1) begin
          if ((vwidth_q == 4'd8) || ((vwidth_q == 4'd2) && (acc < 32'(VI_16))) ||
              ((vwidth_q == 4'd4) && (acc < 32'h00010000))) begin
            proc_err = 1'b1;
          end else begin
            vdone = 1'b1;
            v     = acc;
          end
        end
      end
    end

    if (vdone) begin
      vacc_d = '0;
      ce     = put_count(v);
      unique case (phase_d)
        PH_NIN: begin
          items_d = v;
          if (v != 32'd0) begin
            sl_d    = OUTPOINT_BYTES;
            phase_d = PH_IN_PREFIX;
          end else begin
            phase_d = PH_NOUT;
          end
        end
        PH_IN_SLEN: begin
          if (v != 32'd0) begin
            sl_d    = v;
            phase_d = PH_IN_SCRIPT;
          end else begin
            sl_d    = SEQ_BYTES;
            phase_d = PH_IN_SEQ;
          end
        end
        PH_NOUT: begin
          items_d = v;
          oc_d    = '0;
          if (v != 32'd0) begin
            sl_d    = VALUE_BYTES;
            phase_d = PH_OUT_VALUE;
          end else begin
            phase_d = PH_TAIL;
          end
        end
        default: begin
          if (oc_q == target_output_i) begin
            ce      = put_count({26'd0, rn});
            repl    = 1'b1;
            phase_d = PH_OUT_SKIP;
          end else begin
            phase_d = PH_OUT_COPY;
          end
          sl_d = v;
          if (v == 32'd0) begin
            end_out = 1'b1;
          end
        end
      endcase
      if (held) begin
        en = ce.n + 3'd1;
        ed = {ce.b, 8'h00};
      end else begin
        en = ce.n;
        ed = {8'h00, ce.b};
      end
    end else if (held) begin
      en    = 3'd1;
      ed[0] = 8'h00;
    end

    if (end_out) begin
      oc_d    = oc_q + 16'd1;
      items_d = items_q - 32'd1;
      if (items_q == 32'd1) begin
        phase_d = PH_TAIL;
      end else begin
        sl_d    = VALUE_BYTES;
        phase_d = PH_OUT_VALUE;
      end
    end

    err_d = err_q | proc_err;

    cmd_push_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.kind    = CMD_BYTES;
    cmd_o.nbytes  = en;
    cmd_o.data    = ed;
    cmd_o.repl    = repl;
    cmd_o.rlen    = rn;
    if (opcode_i == OP_LOAD) begin
      cmd_push_o    = accept_i;
      cmd_o         = '0;
      cmd_o.kind    = CMD_LOAD;
      cmd_o.rlen    = repl_index_i;
      cmd_o.data[0] = data_byte_i;
    end else if (last_byte_i) begin
      cmd_push_o   = accept_i;
      cmd_o.repl   = 1'b0;
      cmd_o.end_tx = 1'b1;
      if (!err_d && (phase_d == PH_TAIL) && (tc_d >= 3'd4)) begin
        cmd_o.nbytes = 3'd4;
        cmd_o.data   = {16'd0, tw_d[7:0], tw_d[15:8], tw_d[23:16], tw_d[31:24]};
      end else begin
        cmd_o.nbytes = 3'd1;
        cmd_o.data   = '0;
        cmd_o.status = 1'b1;
      end
    end else if (proc_err) begin
      cmd_push_o   = accept_i;
      cmd_o.nbytes = 3'd1;
      cmd_o.data   = '0;
      cmd_o.repl   = 1'b0;
      cmd_o.status = 1'b1;
    end else if (!err_q && (en != 3'd0)) begin
      cmd_push_o = accept_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VERSION;
      ver_q    <= '0;
      items_q  <= '0;
      vacc_q   <= '0;
      vleft_q  <= '0;
      vwidth_q <= '0;
      sl_q     <= '0;
      oc_q     <= '0;
      tw_q     <= '0;
      tc_q     <= '0;
      err_q    <= 1'b0;
    end else if (accept_i && (opcode_i == OP_TX)) begin
      if (last_byte_i) begin
        phase_q  <= PH_VERSION;
        ver_q    <= '0;
        items_q  <= '0;
        vacc_q   <= '0;
        vleft_q  <= '0;
        vwidth_q <= '0;
        sl_q     <= '0;
        oc_q     <= '0;
        tw_q     <= '0;
        tc_q     <= '0;
        err_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        ver_q    <= ver_d;
        items_q  <= items_d;
        vacc_q   <= vacc_d;
        vleft_q  <= vleft_d;
        vwidth_q <= vwidth_d;
        sl_q     <= sl_d;
        oc_q     <= oc_d;
        tw_q     <= tw_d;
        tc_q     <= tc_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

/* rtl/twr_fifo.sv */
// Two-entry command queue between the parser and the emitter.
module twr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  twr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output twr_pkg::cmd_t data_o
);
  import twr_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wp_q <= ~wp_q;
      end
      if (pop_i && !empty_o) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

endmodule

/* rtl/twr_back.sv */
// Emitter: carries out commands, holds the replacement store and the output register.
module twr_back #(
  parameter int REPL_MAX = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  twr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o,
  output logic          end_of_tx_o,
  output logic          status_o
);
  import twr_pkg::*;

  localparam int AW = (REPL_MAX > 1) ? $clog2(REPL_MAX) : 1;

  logic [7:0]  store_q [REPL_MAX];
  logic [7:0]  rdata_q;
  logic [5:0]  raddr;
  logic        wr_en;

  back_state_e st_q, st_d;
  cmd_t        cmd_q, cmd_d;
  logic [5:0]  pos_q, pos_d;
  logic        ov_q, ov_d;
  logic [7:0]  ob_q, ob_d;
  logic        ol_q, ol_d, oe_q, oe_d, os_q, os_d;
  logic        slot_free;
  logic        lastb;

  assign slot_free = !ov_q || pop;
  assign empty         = !ov_q;
  assign out_byte_o    = ob_q;
  assign last_of_run_o = ol_q;
  assign end_of_tx_o   = oe_q;
  assign status_o      = os_q;

  assign wr_en = (st_q == BK_IDLE) && !cmd_empty_i && (cmd_i.kind == CMD_LOAD) &&
                 (cmd_i.rlen < 6'(REPL_MAX));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cmd_i.rlen[AW-1:0]] <= cmd_i.data[0];
    end
    rdata_q <= store_q[raddr[AW-1:0]];
  end

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    ov_d      = ov_q && !pop;
    ob_d      = ob_q;
    ol_d      = ol_q;
    oe_d      = oe_q;
    os_d      = os_q;
    cmd_pop_o = 1'b0;
    raddr     = pos_q;
    lastb     = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_BYTES) begin
            cmd_d = cmd_i;
            pos_d = '0;
            st_d  = BK_BYTES;
          end
        end
      end
      BK_BYTES: begin
        if (slot_free) begin
          lastb = (pos_q[2:0] == (cmd_q.nbytes - 3'd1));
          ov_d  = 1'b1;
          ob_d  = cmd_q.data[pos_q[2:0]];
          ol_d  = lastb && !(cmd_q.repl && (cmd_q.rlen != 6'd0));
          oe_d  = lastb && cmd_q.end_tx;
          os_d  = cmd_q.status;
          pos_d = pos_q + 6'd1;
          if (lastb) begin
            st_d = (cmd_q.repl && (cmd_q.rlen != 6'd0)) ? BK_RPREP : BK_IDLE;
          end
        end
      end
      BK_RPREP: begin
        raddr = '0;
        pos_d = '0;
        st_d  = BK_REPL;
      end
      BK_REPL: begin
        if (slot_free) begin
          lastb = (pos_q == (cmd_q.rlen - 6'd1));
          ov_d  = 1'b1;
          ob_d  = rdata_q;
          ol_d  = lastb;
          oe_d  = 1'b0;
          os_d  = 1'b0;
          if (lastb) begin
            st_d = BK_IDLE;
          end else begin
            pos_d = pos_q + 6'd1;
            raddr = pos_q + 6'd1;
          end
        end
      end
      default: begin
        st_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pos_q <= pos_d;
    ob_q  <= ob_d;
    ol_q  <= ol_d;
    oe_q  <= oe_d;
    os_q  <= os_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

endmodule

/* rtl/tx_witness_strip_output_replace_unit.sv */
// Top level of the witness-stripping transaction rewriter with output script replacement.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------------
//  input    | in        | push / full               | opcode, data_byte, repl_index, last_byte
//  result   | out       | empty / pop               | out_byte, last_of_run, end_of_tx, status
//  config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The parser takes one byte per cycle while its two-entry command queue has room.
// The emitter sends one result byte per cycle while pop keeps its output slot free; a replaced
// script first passes through a store-read state, and each command is taken in the idle state.
// Reset returns both parts to their idle states; the replacement store is not cleared.
// A stalled result side fills the queue and then raises full.
module tx_witness_strip_output_replace_unit #(
  parameter int REPL_MAX = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  repl_index_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o,
  output logic        end_of_tx_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import twr_pkg::*;

  logic [15:0] target_q;
  logic [5:0]  rlen_q;
  logic        accept;
  logic        cmd_push, cmd_pop, cmd_empty;
  cmd_t        cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      rlen_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARGET_OUTPUT: target_q <= cfg_data_i;
        CFG_REPL_LENGTH:   rlen_q   <= cfg_data_i[5:0];
        default:           target_q <= target_q;
      endcase
    end
  end

  twr_front #(.REPL_MAX(REPL_MAX)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .opcode_i        (opcode_i),
    .data_byte_i     (data_byte_i),
    .repl_index_i    (repl_index_i),
    .last_byte_i     (last_byte_i),
    .target_output_i (target_q),
    .repl_length_i   (rlen_q),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  twr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  twr_back #(.REPL_MAX(REPL_MAX)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .end_of_tx_o   (end_of_tx_o),
    .status_o      (status_o)
  );

`ifndef SYNTHESIS
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_tx_o) |-> last_of_run_o) else $error("end_of_tx without last_of_run");
  a_bad_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o) |-> (out_byte_o == 8'h00 && last_of_run_o))
    else $error("malformed result carries data");
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !(cmd_push && !cmd_pop)) else $error("command lost on full queue");
`endif

endmodule
